[hw/rtl/chacha20_stream_cipher_assert.svh]
// Assertion macros used by the checker file of the stream cipher.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH

// Check a property on the rising clock edge, ignored while reset is high.
`define CC20_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the rising clock edge, reset cycles included.
`define CC20_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cc20_pkg.sv]
// Shared types and constants of the ChaCha20 stream cipher.
// Used by the controller, the datapath and the top level; depends on nothing.
package cc20_pkg;

   // Block geometry
   localparam int WORDS      = 16;
   localparam int CSR_INDEX_W = 3;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_0_7   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_8_15  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_16_23 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_24_31 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_NONCE_0_7 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_NONCE_8_11 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_INIT_CTR  = 3'd6;

   // The four "expand 32-byte k" words
   localparam logic [31:0] SIGMA [4] = '{
      32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
   };

   typedef logic [31:0] word_type;
   typedef word_type    block_type [WORDS];

   // Commands from the controller to the datapath
   typedef struct packed {
      logic       capture;    // latch the accepted word
      logic       load;       // set up the round state for a new block
      logic       round;      // apply one quarter-round step
      logic [2:0] step;       // bit 2: diagonal round, bits 1:0: step in quarter round
      logic       finish;     // add the input state, buffer keystream
      logic       emit_live;  // result from the word on the request ports
      logic       emit_held;  // result from the latched word
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic need_block;       // the word on the request ports needs a fresh block
   } status_type;

endpackage

[hw/rtl/cc20_datapath.sv]
// Datapath of the ChaCha20 stream cipher: configuration, round state,
// keystream buffer and result register. Depends on cc20_pkg.
module cc20_datapath import cc20_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_data,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_start_of_message,
   input  logic                   req_end_of_message,
   output logic [7:0]             rsp_result_byte,
   output logic                   rsp_end_of_message_out
);

   logic [63:0] key_ff [4];
   logic [63:0] key_in [4];
   logic [63:0] nonce_lo_ff, nonce_lo_in;
   logic [31:0] nonce_hi_ff, nonce_hi_in;
   logic [31:0] ctr_init_ff, ctr_init_in;
   logic [31:0] counter_ff, counter_in;
   logic [5:0]  offset_ff, offset_in;
   block_type   work_ff, work_in, ks_ff, ks_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_eom_ff, held_eom_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_eom_ff, out_eom_in;

   logic [31:0] load_counter;
   block_type   load_words, fin_words, step_words;
   word_type    ks_word;
   logic [7:0]  ks_byte;
   logic        diag;
   logic [1:0]  qstep;

   // Build the input state from constants, key, a counter and the nonce
   function automatic block_type init_state(input logic [63:0] k [4],
                                            input logic [63:0] n_lo,
                                            input logic [31:0] n_hi,
                                            input logic [31:0] ctr);
      block_type w;
      for (int i = 0; i < 4; i++) begin
         w[i]       = SIGMA[i];
         w[4 + 2*i] = k[i][31:0];
         w[5 + 2*i] = k[i][63:32];
      end
      w[12] = ctr;
      w[13] = n_lo[31:0];
      w[14] = n_lo[63:32];
      w[15] = n_hi;
      return w;
   endfunction

   assign status.need_block = req_start_of_message || (offset_ff == 6'd0);
   assign load_counter = req_start_of_message ? ctr_init_ff : counter_ff;
   assign load_words   = init_state(key_ff, nonce_lo_ff, nonce_hi_ff, load_counter);
   assign fin_words    = init_state(key_ff, nonce_lo_ff, nonce_hi_ff, counter_ff);

   // One quarter-round step on all four lanes: one add, xor, rotate each
   assign diag  = cmd.step[2];
   assign qstep = cmd.step[1:0];
   always_comb begin
      logic [1:0] lb, lc, ld;
      logic [3:0] ia, ib, ic, id, xi, yi, zi;
      word_type   sum, mix, rot;
      step_words = work_ff;
      for (int j = 0; j < 4; j++) begin
         lb = 2'(j) + {1'b0, diag};
         lc = 2'(j) + {diag, 1'b0};
         ld = 2'(j) + {diag, diag};
         ia = {2'b00, 2'(j)};
         ib = {2'b01, lb};
         ic = {2'b10, lc};
         id = {2'b11, ld};
         xi = qstep[0] ? ic : ia;
         yi = qstep[0] ? id : ib;
         zi = qstep[0] ? ib : id;
         sum = work_ff[xi] + work_ff[yi];
         mix = work_ff[zi] ^ sum;
         case (qstep)
            2'd0:    rot = {mix[15:0], mix[31:16]};
            2'd1:    rot = {mix[19:0], mix[31:20]};
            2'd2:    rot = {mix[23:0], mix[31:24]};
            default: rot = {mix[24:0], mix[31:25]};
         endcase
         step_words[xi] = sum;
         step_words[zi] = rot;
      end
   end

   // Pick the keystream byte at the current offset, little endian
   assign ks_word = ks_ff[offset_ff[5:2]];
   assign ks_byte = ks_word[8*offset_ff[1:0] +: 8];

   // Configuration writes; indexes beyond the list are dropped
   always_comb begin
      key_in      = key_ff;
      nonce_lo_in = nonce_lo_ff;
      nonce_hi_in = nonce_hi_ff;
      ctr_init_in = ctr_init_ff;
      if (csr_write) begin
         case (csr_index)
            REG_KEY_0_7:    key_in[0]   = csr_data;
            REG_KEY_8_15:   key_in[1]   = csr_data;
            REG_KEY_16_23:  key_in[2]   = csr_data;
            REG_KEY_24_31:  key_in[3]   = csr_data;
            REG_NONCE_0_7:  nonce_lo_in = csr_data;
            REG_NONCE_8_11: nonce_hi_in = csr_data[31:0];
            REG_INIT_CTR:   ctr_init_in = csr_data[31:0];
            default:        ;
         endcase
      end
   end

   // Counter, offset, round state and keystream buffer
   always_comb begin
      counter_in = counter_ff;
      offset_in  = offset_ff;
      work_in    = work_ff;
      ks_in      = ks_ff;
      if (cmd.load) begin
         counter_in = load_counter;
         work_in    = load_words;
         if (req_start_of_message) begin
            offset_in = 6'd0;
         end
      end
      if (cmd.round) begin
         work_in = step_words;
      end
      if (cmd.finish) begin
         for (int i = 0; i < WORDS; i++) begin
            ks_in[i] = work_ff[i] + fin_words[i];
         end
         counter_in = counter_ff + 32'd1;
      end
      if (cmd.emit_live || cmd.emit_held) begin
         offset_in = offset_ff + 6'd1;
      end
   end

   // Latched word and result register
   always_comb begin
      held_byte_in = cmd.capture ? req_data_byte : held_byte_ff;
      held_eom_in  = cmd.capture ? req_end_of_message : held_eom_ff;
      out_byte_in  = out_byte_ff;
      out_eom_in   = out_eom_ff;
      if (cmd.emit_live) begin
         out_byte_in = req_data_byte ^ ks_byte;
         out_eom_in  = req_end_of_message;
      end else if (cmd.emit_held) begin
         out_byte_in = held_byte_ff ^ ks_byte;
         out_eom_in  = held_eom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
         end
         nonce_lo_ff <= '0;
         nonce_hi_ff <= '0;
         ctr_init_ff <= '0;
         counter_ff  <= '0;
         offset_ff   <= '0;
      end else begin
         key_ff      <= key_in;
         nonce_lo_ff <= nonce_lo_in;
         nonce_hi_ff <= nonce_hi_in;
         ctr_init_ff <= ctr_init_in;
         counter_ff  <= counter_in;
         offset_ff   <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      ks_ff        <= ks_in;
      held_byte_ff <= held_byte_in;
      held_eom_ff  <= held_eom_in;
      out_byte_ff  <= out_byte_in;
      out_eom_ff   <= out_eom_in;
   end

   assign rsp_result_byte        = out_byte_ff;
   assign rsp_end_of_message_out = out_eom_ff;

endmodule

[hw/rtl/cc20_controller.sv]
// Controller of the ChaCha20 stream cipher: handshakes, block sequencing
// and the round step counter. Depends on cc20_pkg.
module cc20_controller import cc20_pkg::*; #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int TOTAL_STEPS = DOUBLE_ROUNDS * 8;
   localparam int STEP_W      = $clog2(TOTAL_STEPS);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_ROUND  = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;
   localparam logic [1:0] S_EMIT   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              last_step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == STEP_W'(TOTAL_STEPS - 1));
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence: accept, optional block generation, emit
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.step = step_ff[2:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.need_block) begin
                  cmd.load = 1'b1;
                  step_in  = '0;
                  state_in = S_ROUND;
               end else if (out_free) begin
                  cmd.emit_live = 1'b1;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            step_in   = step_ff + STEP_W'(1);
            if (last_step) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit_held = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result until taken; load it on emit
   assign rsp_valid_in = cmd.emit_live || cmd.emit_held || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/chacha20_stream_cipher.sv]
// ChaCha20 stream cipher (IETF, 96-bit nonce), one byte per word.
// Channels: req_ carries data_byte with start and end marks, rsp_ returns
// the byte XOR keystream and the end mark; csr_ writes key, nonce and the
// initial block counter and is always ready; the user must write these only
// while the block is idle, as the block itself does not enforce this.
// A word that starts a message, or falls on a 64-byte boundary, first
// generates a keystream block: load, 8 * DOUBLE_ROUNDS quarter steps
// (one add-xor-rotate step of all four quarter rounds per cycle) and the
// final add; its result is then loaded into the result register once that
// is free. Other words load it as they are accepted, if it is free, and
// follow at one word per cycle while the receiver takes each result. The
// round step counter in the controller sets the block time.
// Reset clears configuration, counter, byte offset and the output valid.
// When the receiver stalls, the result register holds and one more word is
// accepted and parked; then req_ready drops until the result is taken.
// Depends on cc20_pkg, cc20_controller and cc20_datapath.
module chacha20_stream_cipher import cc20_pkg::*; #(
   parameter int DOUBLE_ROUNDS = 10
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_start_of_message,
   input  logic                   req_end_of_message,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_result_byte,
   output logic                   rsp_end_of_message_out,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]            csr_data
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   cc20_controller #(
      .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
   ) u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cc20_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_write              (csr_valid && csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_data_byte          (req_data_byte),
      .req_start_of_message   (req_start_of_message),
      .req_end_of_message     (req_end_of_message),
      .rsp_result_byte        (rsp_result_byte),
      .rsp_end_of_message_out (rsp_end_of_message_out)
   );

endmodule

[hw/rtl/cc20_checker.sv]
// Port-level checks of the ChaCha20 stream cipher, bound to the top level.
// Depends on chacha20_stream_cipher_assert.svh.
`include "chacha20_stream_cipher_assert.svh"

module cc20_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_start_of_message,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_result_byte,
   input logic       rsp_end_of_message_out
);

   // A stalled result stays offered
   `CC20_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped under stall")

   // A stalled result keeps its payload
   `CC20_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_result_byte) && $stable(rsp_end_of_message_out), "result changed under stall")

   // A message start always triggers block generation
   `CC20_ASSERT(a_start_busy, clock, reset, req_valid && req_ready && req_start_of_message |=> !req_ready, "start word did not generate a block")

   // Reset leaves the block idle with no result
   `CC20_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready, "not idle after reset")

endmodule

bind chacha20_stream_cipher cc20_checker u_checker (.*);
